/* design/lsoad_pkg.sv */
`default_nettype none

package lsoad_pkg;

    // item kinds carried on s_axis_tuser
    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_VELOCITY = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    // configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_ANGLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAFE_DIST   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_RATIO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS  = 3'd6;

    // register reset values
    localparam logic signed [19:0] RST_SCAN_START = -20'sd205887;
    localparam logic [15:0] RST_SCAN_STEP  = 16'd1144;
    localparam logic [17:0] RST_HALF_ANGLE = 18'd22876;
    localparam logic [15:0] RST_SAFE_DIST  = 16'd250;
    localparam logic [15:0] RST_TURN_RATIO = 16'd983;
    localparam logic [15:0] RST_HALF_TRACK = 16'd2949;
    localparam logic [15:0] RST_INV_RADIUS = 16'd10240;

    localparam logic [15:0] NO_READING = 16'hFFFF;

    // stream word widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    // shared multiplier
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ANGLE_W     = 26;
    localparam int WHEEL_ACC_W = 25;
    localparam int WHEEL_W     = 24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_MUL_W,
        ST_WQ,
        ST_MUL_L,
        ST_LQ,
        ST_MUL_R,
        ST_RQ,
        ST_SEL,
        ST_MUL_A,
        ST_AQ,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* design/lsoad_mul.sv */
`default_nettype none

module lsoad_mul
    import lsoad_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic signed [MUL_A_W-1:0] a,
    input  wire logic signed [MUL_B_W-1:0] b,
    output logic signed [MUL_P_W-1:0]      p
);

    logic signed [MUL_P_W-1:0] p_reg;

    // one registered signed product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a * b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* design/lidar_sector_obstacle_avoid_drive_unit.sv */
`default_nettype none

// Reactive obstacle avoidance for a differential-drive base fed by a lidar.
// Input words carry a range sample, a velocity command or a control tick,
// chosen by s_axis_tuser; the sample flagged by s_axis_tlast closes a scan
// and latches the front, left and right sector minimums (65535 = nothing
// seen). Only a tick produces an output word: the two wheel speeds, with
// the roomier-side wheel reversed and scaled when the front distance is
// below the safe distance. A velocity command is simply latched; a range
// sample passes angle add, then sector compare and minimum update; a tick
// runs its products (turn rate, left, right, plus the scaling one when
// avoiding) one after another through a single registered 34x17 multiplier.
// The result sits in an output register; a tick only stalls if that register
// is full and not being read. Registers are written through cfg_we,
// cfg_index and cfg_data and should only be changed while the unit is idle.

module lidar_sector_obstacle_avoid_drive_unit
    import lsoad_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // config write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [15:0] range_mm, [16] range_finite, [32:17] linear_speed,
    // [48:33] turn_rate, [55:49] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tlast,   // last_of_scan
    // [1:0] operation
    input  wire logic [1:0]            s_axis_tuser,
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [23:0] left_wheel_speed, [47:24] right_wheel_speed,
    // [48] obstacle_ahead, [49] turning_left, [55:50] zero
    output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

    // config registers
    logic signed [19:0] start_angle_reg;
    logic [15:0] angle_step_reg;
    logic [17:0] half_angle_reg;
    logic [15:0] safe_dist_reg;
    logic [15:0] turn_ratio_reg;
    logic [15:0] half_track_reg;
    logic [15:0] inv_radius_reg;

    // scan state
    logic [15:0] front_min_reg, left_min_reg, right_min_reg;
    logic [15:0] front_dist_reg, left_dist_reg, right_dist_reg;
    logic [23:0] offset_reg;
    logic signed [15:0] lin_reg, ang_reg;

    // sample held for the compare cycle
    logic [15:0] range_reg;
    logic        finite_reg;
    logic        last_reg;
    logic signed [ANGLE_W-1:0] angle_reg;

    // tick datapath
    logic signed [MUL_A_W-1:0]     a_reg;
    logic signed [MUL_B_W-1:0]     b_reg;
    logic signed [MUL_P_W-1:0]     prod;
    logic signed [MUL_A_W-1:0]     wq_reg;
    logic signed [WHEEL_ACC_W-1:0] left_reg, right_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    state_t state_reg, state_next;

    logic s_accept;
    logic out_load;
    op_t  op;
    logic obstacle, turn_left;

    logic signed [MUL_A_W-1:0]     vq;
    logic signed [WHEEL_ACC_W-1:0] sel_wheel;
    logic signed [ANGLE_W-1:0]     mag, half_ext;
    logic        is_front, is_left;
    logic [15:0] front_min_next, left_min_next, right_min_next;

    // round half up, drop 26 fraction bits (wheel formula)
    function automatic logic signed [WHEEL_ACC_W-1:0] round26(
        input logic signed [MUL_P_W-1:0] p
    );
        logic signed [MUL_P_W-1:0] t;
        t = p + {{(MUL_P_W-26){1'b0}}, 1'b1, 25'b0};
        return t[WHEEL_ACC_W+25:26];
    endfunction

    // round half up, drop 16 fraction bits (turn ratio scaling)
    function automatic logic signed [WHEEL_ACC_W-1:0] round16(
        input logic signed [MUL_P_W-1:0] p
    );
        logic signed [MUL_P_W-1:0] t;
        t = p + {{(MUL_P_W-16){1'b0}}, 1'b1, 15'b0};
        return t[WHEEL_ACC_W+15:16];
    endfunction

    function automatic logic [WHEEL_W-1:0] sat24(
        input logic signed [WHEEL_ACC_W-1:0] x
    );
        logic signed [WHEEL_ACC_W-1:0] hi, lo;
        hi = {2'b00, {(WHEEL_W-1){1'b1}}};
        lo = {2'b11, {(WHEEL_W-1){1'b0}}};
        if (x > hi)
            return hi[WHEEL_W-1:0];
        else if (x < lo)
            return lo[WHEEL_W-1:0];
        else
            return x[WHEEL_W-1:0];
    endfunction

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign op        = op_t'(s_axis_tuser);
    assign obstacle  = front_dist_reg < safe_dist_reg;
    // ties go to the right wheel
    assign turn_left = obstacle && (left_dist_reg > right_dist_reg);
    assign vq        = {{2{lin_reg[15]}}, lin_reg, 16'h0000};
    assign sel_wheel = turn_left ? left_reg : right_reg;

    // sector choice; both exact boundaries fall to the right sector
    always_comb
    begin
        mag      = angle_reg[ANGLE_W-1] ? -angle_reg : angle_reg;
        half_ext = {{(ANGLE_W-18){1'b0}}, half_angle_reg};
        is_front = mag < half_ext;
        is_left  = !is_front && (angle_reg > half_ext);

        front_min_next = front_min_reg;
        left_min_next  = left_min_reg;
        right_min_next = right_min_reg;
        if (finite_reg)
        begin
            if (is_front)
            begin
                if (range_reg < front_min_reg)
                    front_min_next = range_reg;
            end
            else if (is_left)
            begin
                if (range_reg < left_min_reg)
                    left_min_next = range_reg;
            end
            else
            begin
                if (range_reg < right_min_reg)
                    right_min_next = range_reg;
            end
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (op)
                        OP_SAMPLE: state_next = ST_SAMPLE;
                        OP_TICK:   state_next = ST_MUL_W;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SAMPLE: state_next = ST_IDLE;
            ST_MUL_W:  state_next = ST_WQ;
            ST_WQ:     state_next = ST_MUL_L;
            ST_MUL_L:  state_next = ST_LQ;
            ST_LQ:     state_next = ST_MUL_R;
            ST_MUL_R:  state_next = ST_RQ;
            ST_RQ:     state_next = obstacle ? ST_SEL : ST_OUT;
            ST_SEL:    state_next = ST_MUL_A;
            ST_MUL_A:  state_next = ST_AQ;
            ST_AQ:     state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_OUT:  out_load = !out_valid_reg || m_axis_tready;
            default:
            begin
                s_axis_tready = 1'b0;
                out_load      = 1'b0;
            end
        endcase
    end

    lsoad_mul u_mul (
        .clk (clk),
        .a   (a_reg),
        .b   (b_reg),
        .p   (prod)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            start_angle_reg <= RST_SCAN_START;
            angle_step_reg  <= RST_SCAN_STEP;
            half_angle_reg  <= RST_HALF_ANGLE;
            safe_dist_reg   <= RST_SAFE_DIST;
            turn_ratio_reg  <= RST_TURN_RATIO;
            half_track_reg  <= RST_HALF_TRACK;
            inv_radius_reg  <= RST_INV_RADIUS;
            front_min_reg   <= NO_READING;
            left_min_reg    <= NO_READING;
            right_min_reg   <= NO_READING;
            front_dist_reg  <= NO_READING;
            left_dist_reg   <= NO_READING;
            right_dist_reg  <= NO_READING;
            offset_reg      <= '0;
            lin_reg         <= '0;
            ang_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCAN_START: start_angle_reg <= cfg_data;
                    CFG_SCAN_STEP:  angle_step_reg  <= cfg_data[15:0];
                    CFG_HALF_ANGLE: half_angle_reg  <= cfg_data[17:0];
                    CFG_SAFE_DIST:  safe_dist_reg   <= cfg_data[15:0];
                    CFG_TURN_RATIO: turn_ratio_reg  <= cfg_data[15:0];
                    CFG_HALF_TRACK: half_track_reg  <= cfg_data[15:0];
                    CFG_INV_RADIUS: inv_radius_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (s_accept && op == OP_VELOCITY)
            begin
                lin_reg <= s_axis_tdata[32:17];
                ang_reg <= s_axis_tdata[48:33];
            end

            // offset steps on every sample, finite or not, and clears on the last
            if (state_reg == ST_SAMPLE)
            begin
                if (last_reg)
                begin
                    front_dist_reg <= front_min_next;
                    left_dist_reg  <= left_min_next;
                    right_dist_reg <= right_min_next;
                    front_min_reg  <= NO_READING;
                    left_min_reg   <= NO_READING;
                    right_min_reg  <= NO_READING;
                    offset_reg     <= '0;
                end
                else
                begin
                    front_min_reg <= front_min_next;
                    left_min_reg  <= left_min_next;
                    right_min_reg <= right_min_next;
                    offset_reg    <= offset_reg + {8'h00, angle_step_reg};
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept && op == OP_SAMPLE)
        begin
            range_reg  <= s_axis_tdata[15:0];
            finite_reg <= s_axis_tdata[16];
            last_reg   <= s_axis_tlast;
            angle_reg  <= {{(ANGLE_W-20){start_angle_reg[19]}}, start_angle_reg}
                        + {{(ANGLE_W-24){1'b0}}, offset_reg};
        end

        case (state_reg)
            ST_IDLE:
            begin
                // w * half_track
                a_reg <= {{(MUL_A_W-16){ang_reg[15]}}, ang_reg};
                b_reg <= {1'b0, half_track_reg};
            end
            ST_WQ:
            begin
                wq_reg <= prod[MUL_A_W-1:0];
                a_reg  <= vq - prod[MUL_A_W-1:0];
                b_reg  <= {1'b0, inv_radius_reg};
            end
            ST_LQ:
            begin
                left_reg <= round26(prod);
                a_reg    <= vq + wq_reg;
            end
            ST_RQ:
            begin
                right_reg <= round26(prod);
            end
            ST_SEL:
            begin
                a_reg <= -{{(MUL_A_W-WHEEL_ACC_W){sel_wheel[WHEEL_ACC_W-1]}}, sel_wheel};
                b_reg <= {1'b0, turn_ratio_reg};
            end
            ST_AQ:
            begin
                if (turn_left)
                    left_reg <= round16(prod);
                else
                    right_reg <= round16(prod);
            end
            default: ;
        endcase

        if (out_load)
        begin
            out_data_reg <= {6'b000000, turn_left, obstacle,
                             sat24(right_reg), sat24(left_reg)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* design/lsoad_checker.sv */
`default_nettype none

module lsoad_checker
    import lsoad_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [1:0]            s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // nothing pending out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output word valid during reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word dropped or changed while stalled");

    // samples and ticks keep the unit busy for at least the next cycle
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
        && (s_axis_tuser == OP_SAMPLE || s_axis_tuser == OP_TICK)
        |=> !s_axis_tready)
        else $error("input taken while a sample or tick is in progress");

    // a new result is only loaded while the input side is busy with a tick
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("output word appeared without a tick in progress");

    // no turn flag without an obstacle
    a_turn_needs_obstacle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[48] |-> !m_axis_tdata[49])
        else $error("turning_left set without obstacle_ahead");

endmodule

bind lidar_sector_obstacle_avoid_drive_unit lsoad_checker u_lsoad_checker (.*);

`default_nettype wire

/* sim/tb_lidar_sector_obstacle_avoid_drive_unit.sv */
`timescale 1ns / 1ps

module tb_lidar_sector_obstacle_avoid_drive_unit;
    import lsoad_pkg::*;

    // op code with no meaning in the block; must be ignored
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int    DRAIN_CYCLES = 16;      // longest tick plus margin
    localparam int    GAP_PCT      = 32;
    localparam int    PRINT_CAP    = 100;
    localparam longint WHEEL_HI    = 64'sd8388607;
    localparam longint WHEEL_LO    = -64'sd8388608;

    // one input word before packing
    typedef struct {
        logic [1:0]  op;
        logic [15:0] range_mm;
        logic        finite;
        logic        last;
        logic [15:0] linear;
        logic [15:0] angular;
    } scan_word_t;

    // one expected output word
    typedef struct packed {
        logic [23:0] left;
        logic [23:0] right;
        logic        obstacle;
        logic        turn_left;
    } wheel_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [15:0] range_mm, [16] range_finite, [32:17] linear_speed,
    // [48:33] turn_rate, [55:49] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;   // last_of_scan
    // [1:0] operation
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [23:0] left_wheel_speed, [47:24] right_wheel_speed,
    // [48] obstacle_ahead, [49] turning_left, [55:50] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    lidar_sector_obstacle_avoid_drive_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: register copies and scan/command state
    // ------------------------------------------------------------------
    logic signed [19:0] m_start    = RST_SCAN_START;
    logic [15:0]        m_step     = RST_SCAN_STEP;
    logic [17:0]        m_half     = RST_HALF_ANGLE;
    logic [15:0]        m_safe     = RST_SAFE_DIST;
    logic [15:0]        m_turn     = RST_TURN_RATIO;
    logic [15:0]        m_track    = RST_HALF_TRACK;
    logic [15:0]        m_invr     = RST_INV_RADIUS;

    logic [15:0]        work_front = NO_READING;
    logic [15:0]        work_left  = NO_READING;
    logic [15:0]        work_right = NO_READING;
    logic [15:0]        dist_front = NO_READING;
    logic [15:0]        dist_left  = NO_READING;
    logic [15:0]        dist_right = NO_READING;
    logic [23:0]        sweep_offset = '0;
    logic signed [15:0] cmd_linear  = '0;
    logic signed [15:0] cmd_angular = '0;

    scan_word_t  pending_words[$];    // waiting for the driver
    wheel_word_t expected_wheels[$];  // predicted, not yet seen

    int   words_queued = 0;
    int   words_sent = 0;             // presented on the slave side
    int   words_taken = 0;            // accepted by the block
    int   mismatch_count = 0;
    logic steady = 1'b0;              // suppresses all idling when set

    scan_word_t  next_word;
    wheel_word_t seen_wheel;

    // round half up: floor((x + 2^(s-1)) / 2^s)
    function automatic longint round_shr(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_wheel(input longint x);
        if (x > WHEEL_HI)
            return WHEEL_HI;
        if (x < WHEEL_LO)
            return WHEEL_LO;
        return x;
    endfunction

    // advance the shadow by one accepted word; a tick queues its wheel word
    task automatic step_avoidance(input logic [1:0] op, input logic [15:0] range_mm,
                                  input logic finite, input logic last,
                                  input logic signed [15:0] linear,
                                  input logic signed [15:0] angular);
        longint      angle;
        longint      mag;
        longint      half;
        longint      vq;
        longint      wq;
        longint      lw;
        longint      rw;
        wheel_word_t res;
        case (op)
            OP_SAMPLE:
            begin
                if (finite)
                begin
                    angle = longint'(m_start) + longint'(sweep_offset);
                    mag   = (angle < 0) ? -angle : angle;
                    half  = longint'(m_half);
                    if (mag < half)
                    begin
                        if (range_mm < work_front)
                            work_front = range_mm;
                    end
                    else if (angle > half)
                    begin
                        if (range_mm < work_left)
                            work_left = range_mm;
                    end
                    else if (range_mm < work_right)
                        // right also takes both exact boundaries
                        work_right = range_mm;
                end
                sweep_offset = sweep_offset + m_step;   // wraps at 2^24
                if (last)
                begin
                    dist_front   = work_front;
                    dist_left    = work_left;
                    dist_right   = work_right;
                    work_front   = NO_READING;
                    work_left    = NO_READING;
                    work_right   = NO_READING;
                    sweep_offset = '0;
                end
            end
            OP_VELOCITY:
            begin
                cmd_linear  = linear;
                cmd_angular = angular;
            end
            OP_TICK:
            begin
                vq = longint'(cmd_linear) * 65536;
                wq = longint'(cmd_angular) * longint'(m_track);
                lw = round_shr((vq - wq) * longint'(m_invr), 26);
                rw = round_shr((vq + wq) * longint'(m_invr), 26);
                res.obstacle  = (dist_front < m_safe);
                res.turn_left = 1'b0;
                if (res.obstacle)
                begin
                    // reverse the wheel on the roomier side; ties go right
                    if (dist_left > dist_right)
                    begin
                        res.turn_left = 1'b1;
                        lw = round_shr(-lw * longint'(m_turn), 16);
                    end
                    else
                        rw = round_shr(-rw * longint'(m_turn), 16);
                end
                lw = clamp_wheel(lw);
                rw = clamp_wheel(rw);
                res.left  = lw[23:0];
                res.right = rw[23:0];
                expected_wheels.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < PRINT_CAP)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic take_gap();
        return !steady && ($urandom_range(0, 99) < GAP_PCT);
    endfunction

    // ------------------------------------------------------------------
    // Slave side: accept at the rising edge, present at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            words_taken++;
            step_avoidance(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16],
                           s_axis_tlast, s_axis_tdata[32:17], s_axis_tdata[48:33]);
        end
    end

    always @(negedge clk)
    begin
        // current word gone (or none shown): offer the next one or idle
        if (rst_n && (!s_axis_tvalid || words_taken == words_sent))
        begin
            if (pending_words.size() != 0 && !take_gap())
            begin
                next_word = pending_words.pop_front();
                s_axis_tdata  <= {7'd0, next_word.angular, next_word.linear,
                                  next_word.finite, next_word.range_mm};
                s_axis_tlast  <= next_word.last;
                s_axis_tuser  <= next_word.op;
                s_axis_tvalid <= 1'b1;
                words_sent++;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Master side: random back-pressure, compare against oldest prediction
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        m_axis_tready <= !take_gap();
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_wheels.size() == 0)
                flag_mismatch("unexpected output word", longint'(m_axis_tdata), 0);
            else
            begin
                seen_wheel = expected_wheels.pop_front();
                if (m_axis_tdata[23:0] !== seen_wheel.left)
                    flag_mismatch("left_wheel_speed", longint'($signed(m_axis_tdata[23:0])),
                                  longint'($signed(seen_wheel.left)));
                if (m_axis_tdata[47:24] !== seen_wheel.right)
                    flag_mismatch("right_wheel_speed",
                                  longint'($signed(m_axis_tdata[47:24])),
                                  longint'($signed(seen_wheel.right)));
                if (m_axis_tdata[48] !== seen_wheel.obstacle)
                    flag_mismatch("obstacle_ahead", longint'(m_axis_tdata[48]),
                                  longint'(seen_wheel.obstacle));
                if (m_axis_tdata[49] !== seen_wheel.turn_left)
                    flag_mismatch("turning_left", longint'(m_axis_tdata[49]),
                                  longint'(seen_wheel.turn_left));
                if (m_axis_tdata[55:50] !== 6'd0)
                    flag_mismatch("padding", longint'(m_axis_tdata[55:50]), 0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic scan_word_t make_word(input logic [1:0] op, input logic [15:0] range_mm,
                                             input logic finite, input logic last,
                                             input logic [15:0] linear,
                                             input logic [15:0] angular);
        scan_word_t w;
        w.op       = op;
        w.range_mm = range_mm;
        w.finite   = finite;
        w.last     = last;
        w.linear   = linear;
        w.angular  = angular;
        return w;
    endfunction

    // all fields but op random; ranges lean towards small values so obstacles show up
    function automatic scan_word_t random_word(input logic [1:0] op);
        scan_word_t w;
        int         pick;
        pick       = $urandom_range(0, 9);
        w.op       = op;
        w.range_mm = (pick < 4) ? 16'($urandom_range(0, 511)) :
                     (pick == 4) ? 16'd0 :
                     (pick == 5) ? 16'd65534 : 16'($urandom_range(0, 65534));
        w.finite   = ($urandom_range(0, 99) < 85);
        w.last     = 1'($urandom_range(0, 1));
        w.linear   = 16'($urandom);
        w.angular  = 16'($urandom);
        return w;
    endfunction

    task automatic push_word(input scan_word_t w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // one well-formed scan, with the odd command or tick slipped in
    task automatic queue_scan(input int n);
        scan_word_t w;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 8)
                push_word(random_word($urandom_range(0, 1) ? OP_TICK : OP_VELOCITY));
            w      = random_word(OP_SAMPLE);
            w.last = (i == n - 1);
            push_word(w);
        end
    endtask

    // mostly short scans followed by command and tick, rest is noise
    task automatic queue_traffic(input int count);
        int first;
        int pick;
        first = words_queued;
        while (words_queued - first < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                queue_scan($urandom_range(1, 12));
                push_word(random_word(OP_VELOCITY));
                push_word(random_word(OP_TICK));
                if ($urandom_range(0, 1))
                    push_word(random_word(OP_TICK));
            end
            else if (pick < 90)
                push_word(random_word(OP_TICK));
            else if (pick < 95)
                push_word(random_word(OP_UNUSED));
            else
                push_word(random_word($urandom_range(0, 1) ? OP_SAMPLE : OP_VELOCITY));
        end
    endtask

    // everything sent and answered, then let stray samples finish
    task automatic wait_drained();
        while (pending_words.size() != 0 || words_taken != words_sent ||
               expected_wheels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_SCAN_START: m_start = val[19:0];
            CFG_SCAN_STEP:  m_step  = val[15:0];
            CFG_HALF_ANGLE: m_half  = val[17:0];
            CFG_SAFE_DIST:  m_safe  = val[15:0];
            CFG_TURN_RATIO: m_turn  = val[15:0];
            CFG_HALF_TRACK: m_track = val[15:0];
            CFG_INV_RADIUS: m_invr  = val[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic write_all(input logic [19:0] start, input logic [15:0] step,
                             input logic [17:0] half, input logic [15:0] safe,
                             input logic [15:0] turn, input logic [15:0] track,
                             input logic [15:0] invr);
        write_reg(CFG_SCAN_START, start);
        write_reg(CFG_SCAN_STEP, 20'(step));
        write_reg(CFG_HALF_ANGLE, 20'(half));
        write_reg(CFG_SAFE_DIST, 20'(safe));
        write_reg(CFG_TURN_RATIO, 20'(turn));
        write_reg(CFG_HALF_TRACK, 20'(track));
        write_reg(CFG_INV_RADIUS, 20'(invr));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // start at -half and step by half: angles -h, 0, +h, +2h give
        // right (boundary), front, right (boundary), left
        write_all(-20'sd22876, 16'd22876, 18'd22876, RST_SAFE_DIST,
                  RST_TURN_RATIO, RST_HALF_TRACK, RST_INV_RADIUS);

        // directed words
        push_word(make_word(OP_VELOCITY, 16'd0, 1'b0, 1'b0, 16'h7FFF, 16'h8000));
        push_word(make_word(OP_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0));   // no scan yet
        push_word(make_word(OP_SAMPLE, 16'd100, 1'b1, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd0, 1'b1, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd300, 1'b1, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd65534, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
        push_word(make_word(OP_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0));   // turn left
        push_word(make_word(OP_VELOCITY, 16'd0, 1'b0, 1'b0, 16'h8000, 16'h7FFF));
        push_word(make_word(OP_TICK, 16'hFFFE, 1'b1, 1'b1, 16'd0, 16'd0));
        // left equals right: the right wheel is reversed
        push_word(make_word(OP_SAMPLE, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd7, 1'b1, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd7, 1'b1, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd7, 1'b1, 1'b1, 16'd0, 16'd0));
        push_word(make_word(OP_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        // unused op with every flag set must leave state alone
        push_word(make_word(OP_UNUSED, 16'd0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
        push_word(make_word(OP_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        // scan of one non-finite sample: every sector empty
        push_word(make_word(OP_SAMPLE, 16'd249, 1'b0, 1'b1, 16'd0, 16'd0));
        push_word(make_word(OP_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        // front just under the safe distance
        push_word(make_word(OP_SAMPLE, 16'd0, 1'b1, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd249, 1'b1, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd5, 1'b0, 1'b0, 16'd0, 16'd0));
        push_word(make_word(OP_SAMPLE, 16'd250, 1'b1, 1'b1, 16'd0, 16'd0));
        push_word(make_word(OP_VELOCITY, 16'd0, 1'b0, 1'b0, 16'h0001, 16'hFFFF));
        push_word(make_word(OP_TICK, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0));
        wait_drained();

        // reset values, one full revolution
        write_all(RST_SCAN_START, RST_SCAN_STEP, RST_HALF_ANGLE, RST_SAFE_DIST,
                  RST_TURN_RATIO, RST_HALF_TRACK, RST_INV_RADIUS);
        queue_scan(360);
        queue_traffic(40);
        wait_drained();

        // upper extremes, no idling; long scan wraps the offset past 2^24
        write_all(-20'sd524288, 16'd65535, 18'd205887, 16'd65534,
                  16'd65535, 16'd65535, 16'd65535);
        steady = 1'b1;
        queue_scan(260);
        queue_traffic(30);
        wait_drained();
        steady = 1'b0;

        // lower extremes
        write_all(20'sd524287, 16'd0, 18'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_traffic(80);
        wait_drained();

        // random settings; the middle one holds the sender until all answered
        for (int r = 0; r < 3; r++)
        begin
            write_all(20'($urandom), 16'($urandom), 18'($urandom_range(0, 205887)),
                      16'($urandom_range(0, 65534)), 16'($urandom), 16'($urandom),
                      16'($urandom));
            queue_traffic(50);
            if (r == 1)
                wait_drained();
            queue_traffic(50);
            wait_drained();
        end

        if (mismatch_count == 0 && expected_wheels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/lsoad_pkg.sv
design/lsoad_mul.sv
design/lidar_sector_obstacle_avoid_drive_unit.sv
design/lsoad_checker.sv
sim/tb_lidar_sector_obstacle_avoid_drive_unit.sv
